>>> design/tap_tempo_median_estimator_core_defines.svh
// assertion macros for the tap tempo estimator core
// expects clk and rst_n in the scope where a macro is used
`ifndef TAP_TEMPO_MEDIAN_ESTIMATOR_CORE_DEFINES_SVH
`define TAP_TEMPO_MEDIAN_ESTIMATOR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TTE_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tte: same-cycle check failed");

// next-cycle implication, checked out of reset
`define TTE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tte: next-cycle check failed");

`endif

>>> design/tte_pkg.sv
// shared constants, widths and control structs for the tap tempo estimator
// no dependencies
package tte_pkg;

    localparam int MAX_TAPS   = 8;
    localparam int TIME_BITS  = 32;
    localparam int NGAPS      = MAX_TAPS - 1;

    localparam int CNT_W      = $clog2(MAX_TAPS + 1);
    localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
    localparam int GAP_IDX_W  = (NGAPS > 1) ? $clog2(NGAPS) : 1;
    localparam int RANK_W     = $clog2(NGAPS + 1);

    localparam int WIN_W      = 16;
    localparam int BPM_W      = 10;
    localparam int FRAC_W     = 8;
    localparam int TEMPO_W    = 18;
    localparam int HELD_W     = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MINUTE_Q8  = 60000 * 256;
    localparam int QUOT_W     = $clog2(MINUTE_Q8 + 1);
    localparam int DIV_CNT_W  = $clog2(QUOT_W);

    localparam logic [TEMPO_W-1:0]   TEMPO_RESET   = TEMPO_W'(30720);
    localparam logic [WIN_W-1:0]     WINDOW_RESET  = WIN_W'(2000);
    localparam logic [BPM_W-1:0]     FLOOR_RESET   = BPM_W'(30);
    localparam logic [BPM_W-1:0]     CEILING_RESET = BPM_W'(300);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = CFG_IDX_W'(2);

    typedef struct packed {
        logic capture;
        logic drop_stale;
        logic append;
        logic load_gaps;
        logic rank_step;
        logic div_step;
        logic clamp;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic stale;
        logic multi;
        logic found;
        logic med_zero;
        logic div_last;
    } stat_t;

endpackage

>>> design/tte_if.sv
// valid/ready channel interfaces: tap input, tempo result and config write
// depends on tte_pkg
interface tte_tap_if;
    logic                           valid;
    logic                           ready;
    logic [tte_pkg::TIME_BITS-1:0]  tap_time_ms;

    modport source (output valid, output tap_time_ms, input ready);
    modport sink   (input valid, input tap_time_ms, output ready);
endinterface

interface tte_res_if;
    logic                           valid;
    logic                           ready;
    logic [tte_pkg::TEMPO_W-1:0]    tempo_fixed;
    logic                           updated;
    logic [tte_pkg::HELD_W-1:0]     taps_held;

    modport source (output valid, output tempo_fixed, output updated, output taps_held,
                    input ready);
    modport sink   (input valid, input tempo_fixed, input updated, input taps_held,
                    output ready);
endinterface

interface tte_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tte_pkg::CFG_IDX_W-1:0]  index;
    logic [tte_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/tap_tempo_median_estimator_core.sv
// top level of the tap tempo estimator: channel wiring, sequencer and datapath
// depends on tte_pkg, tte_if, tte_ctrl, tte_dp and the defines header
//
// Takes one tap timestamp (ms, wrapping) per item and returns one item with the
// current tempo in BPM (8 fraction bits), an updated flag and the number of taps
// held. Taps are handled one at a time. The sequencer drops stale taps one by
// one, appends the new tap and, once two or more taps are held, tries the
// intervals in turn in a rank search (up to MAX_TAPS-1) for the median, runs the
// bit-serial divider that forms 60000*256/median and clamps the quotient; a zero
// median skips the divider and the clamp. The result is then offered and the
// next tap can be taken in the cycle after the result is loaded.
// The result sits in an output register, so a tap can be accepted while the
// previous result waits; a finished tap then holds until that register frees.
// Config writes are taken every cycle.
`include "tap_tempo_median_estimator_core_defines.svh"

module tap_tempo_median_estimator_core (
    input  logic        clk,
    input  logic        rst_n,
    tte_tap_if.sink     tap,
    tte_res_if.source   res,
    tte_cfg_if.sink     cfg
);

    tte_pkg::cmd_t  cmd;
    tte_pkg::stat_t stat;
    logic           tap_ready;
    logic           res_valid;

    assign tap.ready = tap_ready;
    assign res.valid = res_valid;
    assign cfg.ready = 1'b1;

    tte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (tap.valid),
        .tap_ready (tap_ready),
        .res_ready (res.ready),
        .res_valid (res_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    tte_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .tap_time_ms (tap.tap_time_ms),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .stat        (stat),
        .tempo_fixed (res.tempo_fixed),
        .updated     (res.updated),
        .taps_held   (res.taps_held)
    );

    // sequencer is busy right after taking a tap
    `TTE_ASSERT_NEXT(a_busy_after_tap, tap.valid && tap_ready, !tap_ready)
    // a freshly loaded result is offered with at least one tap held
    `TTE_ASSERT_NEXT(a_result_loaded, cmd.load_out, res_valid && (res.taps_held != '0))
    // a new estimate needs at least one interval
    `TTE_ASSERT_IMPL(a_update_needs_two, res_valid && res.updated, res.taps_held >= 4'd2)

endmodule

>>> design/tte_ctrl.sv
// sequencer for the tap tempo estimator: steps one tap through the datapath
// depends on tte_pkg
module tte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tap_valid,
    output logic            tap_ready,
    input  logic            res_ready,
    output logic            res_valid,
    input  tte_pkg::stat_t  stat,
    output tte_pkg::cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_AGE    = 8'b0000_0010,
        S_APPEND = 8'b0000_0100,
        S_GAPS   = 8'b0000_1000,
        S_RANK   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_CLAMP  = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   slot_free;

    assign slot_free = !res_valid_reg || res_ready;
    assign tap_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (tap_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_AGE;
                end
            end
            S_AGE:
            begin
                // one stale tap leaves per cycle
                if (stat.stale)
                    cmd.drop_stale = 1'b1;
                else
                    state_next = S_APPEND;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_GAPS;
            end
            S_GAPS:
            begin
                cmd.load_gaps = 1'b1;
                state_next    = stat.multi ? S_RANK : S_FIN;
            end
            S_RANK:
            begin
                cmd.rank_step = 1'b1;
                if (stat.found)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.med_zero)
                    state_next = S_FIN;
                else
                begin
                    cmd.div_step = 1'b1;
                    if (stat.div_last)
                        state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

>>> design/tte_dp.sv
// datapath: tap store, interval ranking, restoring divider, clamp, config and result regs
// depends on tte_pkg
module tte_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tte_pkg::TIME_BITS-1:0]   tap_time_ms,
    input  logic                            cfg_valid,
    input  logic [tte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tte_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  tte_pkg::cmd_t                   cmd,
    output tte_pkg::stat_t                  stat,
    output logic [tte_pkg::TEMPO_W-1:0]     tempo_fixed,
    output logic                            updated,
    output logic [tte_pkg::HELD_W-1:0]      taps_held
);

    localparam int TB = tte_pkg::TIME_BITS;
    localparam int QW = tte_pkg::QUOT_W;

    // config registers
    logic [tte_pkg::WIN_W-1:0]       window_reg;
    logic [tte_pkg::BPM_W-1:0]       floor_reg;
    logic [tte_pkg::BPM_W-1:0]       ceiling_reg;

    // tap store, oldest first
    logic [TB-1:0]                   taps_reg [tte_pkg::MAX_TAPS];
    logic [tte_pkg::CNT_W-1:0]       count_reg;
    logic [tte_pkg::CNT_W-1:0]       count_next;
    logic [TB-1:0]                   now_reg;
    logic                            full;
    logic                            shift;
    logic [tte_pkg::TAP_IDX_W-1:0]   widx;
    logic [TB-1:0]                   age;

    // intervals and ranking
    logic [TB-1:0]                   gap_reg [tte_pkg::NGAPS];
    logic [tte_pkg::RANK_W-1:0]      n_reg;
    logic [tte_pkg::RANK_W-1:0]      half;
    logic [tte_pkg::GAP_IDX_W-1:0]   k_reg;
    logic [TB-1:0]                   cand;
    logic [tte_pkg::NGAPS-1:0]       below;
    logic [tte_pkg::RANK_W-1:0]      rank;

    // divider
    logic [TB-1:0]                   med_reg;
    logic [TB-1:0]                   rem_reg;
    logic [TB-1:0]                   rem_next;
    logic [QW-1:0]                   dvd_reg;
    logic [QW-1:0]                   quot_reg;
    logic [tte_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [TB:0]                     trial;
    logic                            ge;

    // clamp and result
    logic [tte_pkg::TEMPO_W-1:0]     tempo_reg;
    logic [tte_pkg::TEMPO_W-1:0]     tempo_next;
    logic [tte_pkg::TEMPO_W-1:0]     lo;
    logic [tte_pkg::TEMPO_W-1:0]     hi;
    logic                            upd_reg;
    logic [tte_pkg::TEMPO_W-1:0]     res_tempo_reg;
    logic                            res_upd_reg;
    logic [tte_pkg::HELD_W-1:0]      res_held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= tte_pkg::WINDOW_RESET;
            floor_reg   <= tte_pkg::FLOOR_RESET;
            ceiling_reg <= tte_pkg::CEILING_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tte_pkg::CFG_WINDOW:  window_reg  <= cfg_data[tte_pkg::WIN_W-1:0];
                tte_pkg::CFG_FLOOR:   floor_reg   <= cfg_data[tte_pkg::BPM_W-1:0];
                tte_pkg::CFG_CEILING: ceiling_reg <= cfg_data[tte_pkg::BPM_W-1:0];
                default:              ;
            endcase
        end
    end

    // ---- tap store ----
    assign full  = (count_reg == tte_pkg::CNT_W'(tte_pkg::MAX_TAPS));
    assign shift = cmd.drop_stale || (cmd.append && full);
    assign widx  = full ? tte_pkg::TAP_IDX_W'(tte_pkg::MAX_TAPS - 1)
                        : count_reg[tte_pkg::TAP_IDX_W-1:0];
    assign age   = now_reg - taps_reg[0];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.drop_stale)
            count_next = count_reg - 1'b1;
        else if (cmd.append && !full)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            now_reg <= tap_time_ms;
    end

    for (genvar i = 0; i < tte_pkg::MAX_TAPS - 1; i++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (cmd.append && (widx == tte_pkg::TAP_IDX_W'(i)))
                taps_reg[i] <= now_reg;
            else if (shift)
                taps_reg[i] <= taps_reg[i+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && (widx == tte_pkg::TAP_IDX_W'(tte_pkg::MAX_TAPS - 1)))
            taps_reg[tte_pkg::MAX_TAPS-1] <= now_reg;
    end

    // ---- intervals and rank search ----
    for (genvar j = 0; j < tte_pkg::NGAPS; j++)
    begin : g_gap
        always_ff @(posedge clk)
        begin
            if (cmd.load_gaps)
                gap_reg[j] <= taps_reg[j+1] - taps_reg[j];
        end

        // ties rank by position, like a stable sort
        assign below[j] = (tte_pkg::RANK_W'(j) < n_reg) &&
                          ((gap_reg[j] < cand) ||
                           ((gap_reg[j] == cand) && (tte_pkg::GAP_IDX_W'(j) < k_reg)));
    end

    assign cand = gap_reg[k_reg];
    assign half = n_reg >> 1;
    assign rank = tte_pkg::RANK_W'($countones(below));

    always_ff @(posedge clk)
    begin
        if (cmd.load_gaps)
        begin
            n_reg <= tte_pkg::RANK_W'(count_reg - 1'b1);
            k_reg <= '0;
        end
        else if (cmd.rank_step)
            k_reg <= k_reg + 1'b1;
    end

    // ---- restoring divider, one quotient bit per cycle ----
    assign trial    = {rem_reg, dvd_reg[QW-1]};
    assign ge       = (trial >= {1'b0, med_reg});
    assign rem_next = ge ? TB'(trial - {1'b0, med_reg}) : trial[TB-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rank_step && stat.found)
        begin
            med_reg     <= cand;
            rem_reg     <= '0;
            dvd_reg     <= QW'(tte_pkg::MINUTE_Q8);
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            dvd_reg     <= dvd_reg << 1;
            quot_reg    <= {quot_reg[QW-2:0], ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // ---- clamp, floor tested first ----
    assign lo = {floor_reg, {tte_pkg::FRAC_W{1'b0}}};
    assign hi = {ceiling_reg, {tte_pkg::FRAC_W{1'b0}}};

    always_comb
    begin
        if (quot_reg < QW'(lo))
            tempo_next = lo;
        else if (quot_reg > QW'(hi))
            tempo_next = hi;
        else
            tempo_next = tte_pkg::TEMPO_W'(quot_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg <= tte_pkg::TEMPO_RESET;
            upd_reg   <= 1'b0;
        end
        else if (cmd.capture)
            upd_reg   <= 1'b0;
        else if (cmd.clamp)
        begin
            tempo_reg <= tempo_next;
            upd_reg   <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_tempo_reg <= tempo_reg;
            res_upd_reg   <= upd_reg;
            res_held_reg  <= tte_pkg::HELD_W'(count_reg);
        end
    end

    assign stat.stale    = (count_reg != '0) && (age > TB'(window_reg));
    assign stat.multi    = (count_reg >= tte_pkg::CNT_W'(2));
    assign stat.found    = (rank == half);
    assign stat.med_zero = (med_reg == '0);
    assign stat.div_last = (div_cnt_reg == tte_pkg::DIV_CNT_W'(QW - 1));

    assign tempo_fixed = res_tempo_reg;
    assign updated     = res_upd_reg;
    assign taps_held   = res_held_reg;

endmodule
